### design/btca_pkg.sv
// Shared types, constants and helper functions for the barometric compensation unit.
package btca_pkg;

  localparam logic [63:0] FINE_OFFSET = 64'd128000;
  localparam logic [63:0] RAW_FULL    = 64'd1048576;
  localparam logic [63:0] PRESS_SCALE = 64'd3125;
  localparam logic [63:0] ROUND_HALF  = 64'd128;
  localparam int          P4_SHIFT    = 35;
  localparam logic [63:0] P1_BIAS     = 64'h0000_8000_0000_0000;

  localparam logic [2:0] REG_CAL_TEMP   = 3'd0;
  localparam logic [2:0] REG_CAL_PLOW   = 3'd1;
  localparam logic [2:0] REG_CAL_PMID   = 3'd2;
  localparam logic [2:0] REG_CAL_PHIGH  = 3'd3;
  localparam logic [2:0] REG_AVG_LEN    = 3'd4;

  typedef enum logic [5:0] {
    S_IDLE, S_T1, S_T2, S_T3, S_T4, S_T5, S_T6, S_T7, S_T8,
    S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_P8, S_P9, S_P10, S_P11,
    S_P12, S_P13, S_P14, S_P15, S_P16, S_P17, S_P18, S_P19, S_P20, S_P21,
    S_P22, S_OUT
  } state_t;

  typedef enum logic [5:0] {
    OP_NONE, OP_LOAD, OP_MUL_T2, OP_SET_A, OP_MUL_DD, OP_MUL_T3, OP_SET_FINE,
    OP_TEMP_ACC, OP_DIV_T, OP_TEMP_HOLD, OP_MUL_AA, OP_SET_AA, OP_MUL_P6,
    OP_SET_B, OP_MUL_P5, OP_ADD_B, OP_MUL_P3, OP_SET_C, OP_MUL_P2, OP_ADD_C,
    OP_MUL_P1, OP_SET_DEN, OP_INVALID, OP_MUL_N, OP_DIV_P, OP_SET_Q,
    OP_MUL_P8, OP_SET_C2, OP_MUL_RR, OP_MUL_P9, OP_PRESS_ACC, OP_DIV_PM,
    OP_PRESS_HOLD, OP_PUBLISH
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic temp_done;
    logic press_done;
    logic den_zero;
    logic out_full;
  } stat_t;

  typedef struct packed {
    logic [47:0] temp;
    logic [63:0] pwords_lo;
    logic [63:0] pwords_mid;
    logic [15:0] pwords_hi;
    logic [7:0]  avg_len;
  } cal_t;

  function automatic logic [63:0] sx16(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  function automatic logic [63:0] asr(input logic [63:0] v, input logic [5:0] sh);
    return $unsigned($signed(v) >>> sh);
  endfunction

  function automatic logic [63:0] mag64(input logic [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

endpackage

### design/btca_mul.sv
// Shared 64x64 multiplier, low 64 bits, built from one 32x32 unit over three passes.
module btca_mul
  import btca_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] op_a,
  input  logic [63:0] op_b,
  output logic        busy,
  output logic [63:0] product
);

  logic [1:0]  step_r;
  logic        busy_r;
  logic [63:0] a_r, b_r, acc_r;
  logic [31:0] x, y;
  logic [63:0] part;

  always_comb begin
    unique case (step_r)
      2'd0:    begin x = a_r[31:0];  y = b_r[31:0];  end
      2'd1:    begin x = a_r[31:0];  y = b_r[63:32]; end
      default: begin x = a_r[63:32]; y = b_r[31:0];  end
    endcase
    part = 64'(x) * 64'(y);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= 2'd0;
    end else if (start) begin
      busy_r <= 1'b1;
      step_r <= 2'd0;
      a_r    <= op_a;
      b_r    <= op_b;
    end else if (busy_r) begin
      if (step_r == 2'd0) begin
        acc_r <= part;
      end else begin
        acc_r[63:32] <= acc_r[63:32] + part[31:0];
      end
      if (step_r == 2'd2) begin
        busy_r <= 1'b0;
        step_r <= 2'd0;
      end else begin
        step_r <= step_r + 2'd1;
      end
    end
  end

  assign busy    = busy_r;
  assign product = acc_r;

endmodule

### design/btca_div.sv
// Shared unsigned 64-bit restoring divider, one quotient bit per cycle.
module btca_div
  import btca_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [63:0] divisor,
  output logic        busy,
  output logic [63:0] quotient
);

  logic        busy_r;
  logic [5:0]  cnt_r;
  logic [63:0] rem_r, quo_r, dvs_r;
  logic [64:0] rem_sh, diff;
  logic        ge;

  always_comb begin
    rem_sh = {rem_r, quo_r[63]};
    diff   = rem_sh - {1'b0, dvs_r};
    ge     = !diff[64];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 6'd0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= 6'd63;
      rem_r  <= 64'd0;
      quo_r  <= dividend;
      dvs_r  <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[63:0] : rem_sh[63:0];
      quo_r <= {quo_r[62:0], ge};
      if (cnt_r == 6'd0) begin
        busy_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r - 6'd1;
      end
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

### design/btca_ctrl.sv
// Sequencer that steps one reading through the compensation and averaging datapath.
module btca_ctrl
  import btca_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  input  stat_t stat,
  output logic  in_ready,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_T1;
        end
      end
      S_T1:  begin cmd.op = OP_MUL_T2;   state_nxt = S_T2; end
      S_T2:  begin cmd.op = OP_SET_A;    state_nxt = S_T3; end
      S_T3:  begin cmd.op = OP_MUL_DD;   state_nxt = S_T4; end
      S_T4:  begin cmd.op = OP_MUL_T3;   state_nxt = S_T5; end
      S_T5:  begin cmd.op = OP_SET_FINE; state_nxt = S_T6; end
      S_T6:  begin cmd.op = OP_TEMP_ACC; state_nxt = S_T7; end
      S_T7: begin
        if (stat.temp_done) begin
          cmd.op    = OP_DIV_T;
          state_nxt = S_T8;
        end else begin
          state_nxt = S_P1;
        end
      end
      S_T8:  begin cmd.op = OP_TEMP_HOLD; state_nxt = S_P1;  end
      S_P1:  begin cmd.op = OP_MUL_AA;    state_nxt = S_P2;  end
      S_P2:  begin cmd.op = OP_SET_AA;    state_nxt = S_P3;  end
      S_P3:  begin cmd.op = OP_MUL_P6;    state_nxt = S_P4;  end
      S_P4:  begin cmd.op = OP_SET_B;     state_nxt = S_P5;  end
      S_P5:  begin cmd.op = OP_MUL_P5;    state_nxt = S_P6;  end
      S_P6:  begin cmd.op = OP_ADD_B;     state_nxt = S_P7;  end
      S_P7:  begin cmd.op = OP_MUL_P3;    state_nxt = S_P8;  end
      S_P8:  begin cmd.op = OP_SET_C;     state_nxt = S_P9;  end
      S_P9:  begin cmd.op = OP_MUL_P2;    state_nxt = S_P10; end
      S_P10: begin cmd.op = OP_ADD_C;     state_nxt = S_P11; end
      S_P11: begin cmd.op = OP_MUL_P1;    state_nxt = S_P12; end
      S_P12: begin cmd.op = OP_SET_DEN;   state_nxt = S_P13; end
      S_P13: begin
        // zero divisor: flag and skip the pressure path
        if (stat.den_zero) begin
          cmd.op    = OP_INVALID;
          state_nxt = S_OUT;
        end else begin
          cmd.op    = OP_MUL_N;
          state_nxt = S_P14;
        end
      end
      S_P14: begin cmd.op = OP_DIV_P;     state_nxt = S_P15; end
      S_P15: begin cmd.op = OP_SET_Q;     state_nxt = S_P16; end
      S_P16: begin cmd.op = OP_MUL_P8;    state_nxt = S_P17; end
      S_P17: begin cmd.op = OP_SET_C2;    state_nxt = S_P18; end
      S_P18: begin cmd.op = OP_MUL_RR;    state_nxt = S_P19; end
      S_P19: begin cmd.op = OP_MUL_P9;    state_nxt = S_P20; end
      S_P20: begin cmd.op = OP_PRESS_ACC; state_nxt = S_P21; end
      S_P21: begin
        if (stat.press_done) begin
          cmd.op    = OP_DIV_PM;
          state_nxt = S_P22;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_P22: begin cmd.op = OP_PRESS_HOLD; state_nxt = S_OUT; end
      S_OUT: begin
        if (!stat.out_full) begin
          cmd.op    = OP_PUBLISH;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    // hold while the multiplier or divider is still working
    if (stat.busy && state_r != S_IDLE) begin
      cmd.op    = OP_NONE;
      state_nxt = state_r;
    end
  end

endmodule

### design/btca_dp.sv
// Datapath: working registers, block accumulators, shared multiplier and divider, output register.
module btca_dp
  import btca_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  input  cal_t               cal,
  input  logic [19:0]        raw_temperature,
  input  logic [19:0]        raw_pressure,
  input  logic               out_ready,
  output stat_t              stat,
  output logic               out_valid,
  output logic signed [15:0] temperature_mean,
  output logic [31:0]        pressure_mean,
  output logic signed [31:0] fine_temperature,
  output logic               temperature_mean_new,
  output logic               pressure_mean_new,
  output logic               pressure_invalid
);

  logic [19:0] rt_r, rp_r;
  logic [63:0] fine_r, a_r, b_r, c_r;
  logic [23:0] tsum_r;
  logic [7:0]  ttally_r, ptally_r;
  logic [15:0] theld_r;
  logic [39:0] psum_r;
  logic [31:0] pheld_r;
  logic        tdone_r, pdone_r, tnew_r, pnew_r, pinv_r, neg_r;
  logic        out_valid_r;
  logic [15:0] out_tm_r;
  logic [31:0] out_pm_r, out_fine_r;
  logic        out_tnew_r, out_pnew_r, out_pinv_r;

  logic [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic [63:0] mul_a, mul_b, prod, div_n, div_d, quo, dd, rr;
  logic        mul_start, div_start, mul_busy, div_busy;
  logic [63:0] tv, ps;
  logic [15:0] tsat;
  logic [31:0] psat;
  logic [7:0]  ttally_inc, ptally_inc;
  logic [15:0] tq;

  always_comb begin
    t1 = {48'd0, cal.temp[15:0]};
    t2 = sx16(cal.temp[31:16]);
    t3 = sx16(cal.temp[47:32]);
    p1 = {48'd0, cal.pwords_lo[15:0]};
    p2 = sx16(cal.pwords_lo[31:16]);
    p3 = sx16(cal.pwords_lo[47:32]);
    p4 = sx16(cal.pwords_lo[63:48]);
    p5 = sx16(cal.pwords_mid[15:0]);
    p6 = sx16(cal.pwords_mid[31:16]);
    p7 = sx16(cal.pwords_mid[47:32]);
    p8 = sx16(cal.pwords_mid[63:48]);
    p9 = sx16(cal.pwords_hi);
  end

  // operand routing for the shared units
  always_comb begin
    dd        = {44'd0, rt_r >> 4} - t1;
    rr        = asr(b_r, 6'd13);
    mul_a     = 64'd0;
    mul_b     = 64'd0;
    mul_start = 1'b1;
    unique case (cmd.op)
      OP_MUL_T2: begin mul_a = {44'd0, rt_r >> 3} - (t1 << 1); mul_b = t2; end
      OP_MUL_DD: begin mul_a = dd; mul_b = dd; end
      OP_MUL_T3: begin mul_a = asr(prod, 6'd12); mul_b = t3; end
      OP_MUL_AA: begin mul_a = a_r; mul_b = a_r; end
      OP_MUL_P6: begin mul_a = c_r; mul_b = p6; end
      OP_MUL_P5: begin mul_a = a_r; mul_b = p5; end
      OP_MUL_P3: begin mul_a = c_r; mul_b = p3; end
      OP_MUL_P2: begin mul_a = a_r; mul_b = p2; end
      OP_MUL_P1: begin mul_a = c_r; mul_b = p1; end
      OP_MUL_N: begin
        mul_a = ((RAW_FULL - {44'd0, rp_r}) << 31) - b_r;
        mul_b = PRESS_SCALE;
      end
      OP_MUL_P8: begin mul_a = b_r; mul_b = p8; end
      OP_MUL_RR: begin mul_a = rr; mul_b = rr; end
      OP_MUL_P9: begin mul_a = prod; mul_b = p9; end
      default:   mul_start = 1'b0;
    endcase

    div_n     = 64'd0;
    div_d     = 64'd0;
    div_start = 1'b1;
    unique case (cmd.op)
      OP_DIV_T: begin
        div_n = {40'd0, tsum_r[23] ? (24'd0 - tsum_r) : tsum_r};
        div_d = {56'd0, ttally_r};
      end
      OP_DIV_P: begin
        div_n = mag64(prod);
        div_d = mag64(a_r);
      end
      OP_DIV_PM: begin
        div_n = {24'd0, psum_r};
        div_d = {56'd0, ptally_r};
      end
      default: div_start = 1'b0;
    endcase
  end

  // per-reading temperature and pressure, saturated
  always_comb begin
    tv = asr((fine_r << 2) + fine_r + ROUND_HALF, 6'd8);
    if ($signed(tv) > 64'sd32767) begin
      tsat = 16'h7FFF;
    end else if ($signed(tv) < -64'sd32768) begin
      tsat = 16'h8000;
    end else begin
      tsat = tv[15:0];
    end
    ps = asr(b_r + asr(prod, 6'd25) + c_r, 6'd8) + (p7 << 4);
    if (ps[63]) begin
      psat = 32'd0;
    end else if (ps[62:32] != 31'd0) begin
      psat = 32'hFFFF_FFFF;
    end else begin
      psat = ps[31:0];
    end
    ttally_inc = ttally_r + 8'd1;
    ptally_inc = ptally_r + 8'd1;
    tq         = quo[15:0];
  end

  btca_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .op_a    (mul_a),
    .op_b    (mul_b),
    .busy    (mul_busy),
    .product (prod)
  );

  btca_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .busy     (div_busy),
    .quotient (quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tsum_r      <= 24'd0;
      ttally_r    <= 8'd0;
      theld_r     <= 16'd0;
      psum_r      <= 40'd0;
      ptally_r    <= 8'd0;
      pheld_r     <= 32'd0;
      tdone_r     <= 1'b0;
      pdone_r     <= 1'b0;
      tnew_r      <= 1'b0;
      pnew_r      <= 1'b0;
      pinv_r      <= 1'b0;
      neg_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && cmd.op != OP_PUBLISH) begin
        out_valid_r <= 1'b0;
      end
      unique case (cmd.op)
        OP_LOAD: begin
          rt_r   <= raw_temperature;
          rp_r   <= raw_pressure;
          tnew_r <= 1'b0;
          pnew_r <= 1'b0;
          pinv_r <= 1'b0;
        end
        OP_SET_A:    a_r    <= asr(prod, 6'd11);
        OP_SET_FINE: fine_r <= a_r + asr(prod, 6'd14);
        OP_TEMP_ACC: begin
          tsum_r   <= tsum_r + {{8{tsat[15]}}, tsat};
          ttally_r <= ttally_inc;
          tdone_r  <= ttally_inc >= cal.avg_len;
          a_r      <= fine_r - FINE_OFFSET;
        end
        OP_DIV_T:  neg_r <= tsum_r[23];
        OP_TEMP_HOLD: begin
          theld_r  <= neg_r ? (16'd0 - tq) : tq;
          tsum_r   <= 24'd0;
          ttally_r <= 8'd0;
          tnew_r   <= 1'b1;
        end
        OP_SET_AA:  c_r <= prod;
        OP_SET_B:   b_r <= prod;
        OP_ADD_B:   b_r <= b_r + (prod << 17) + (p4 << P4_SHIFT);
        OP_SET_C:   c_r <= asr(prod, 6'd8);
        OP_ADD_C:   c_r <= c_r + (prod << 12) + P1_BIAS;
        OP_SET_DEN: a_r <= asr(prod, 6'd33);
        OP_INVALID: pinv_r <= 1'b1;
        OP_DIV_P:   neg_r <= prod[63] ^ a_r[63];
        OP_SET_Q:   b_r <= neg_r ? (64'd0 - quo) : quo;
        OP_SET_C2:  c_r <= asr(prod, 6'd19);
        OP_PRESS_ACC: begin
          psum_r   <= psum_r + {8'd0, psat};
          ptally_r <= ptally_inc;
          pdone_r  <= ptally_inc >= cal.avg_len;
        end
        OP_PRESS_HOLD: begin
          pheld_r  <= quo[31:0];
          psum_r   <= 40'd0;
          ptally_r <= 8'd0;
          pnew_r   <= 1'b1;
        end
        OP_PUBLISH: begin
          out_valid_r <= 1'b1;
          out_tm_r    <= theld_r;
          out_pm_r    <= pinv_r ? 32'd0 : pheld_r;
          out_fine_r  <= fine_r[31:0];
          out_tnew_r  <= tnew_r;
          out_pnew_r  <= pnew_r;
          out_pinv_r  <= pinv_r;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    stat.busy       = mul_busy || div_busy;
    stat.temp_done  = tdone_r;
    stat.press_done = pdone_r;
    stat.den_zero   = (a_r == 64'd0);
    stat.out_full   = out_valid_r && !out_ready;
  end

  assign out_valid            = out_valid_r;
  assign temperature_mean     = $signed(out_tm_r);
  assign pressure_mean        = out_pm_r;
  assign fine_temperature     = $signed(out_fine_r);
  assign temperature_mean_new = out_tnew_r;
  assign pressure_mean_new    = out_pnew_r;
  assign pressure_invalid     = out_pinv_r;

endmodule

### design/baro_temp_compensate_average_unit.sv
// Top level: calibration registers on the APB port, sequencer and datapath.
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  cfg     | psel/penable/pready  | paddr (8-byte stride), pwdata/prdata 64 bit
//  in      | in_valid/in_ready    | in_raw_temperature, in_raw_pressure
//  out     | out_valid/out_ready  | means, fine temperature, new/invalid flags
//
// One reading at a time; in_ready is high only while the sequencer is idle.
// A reading runs the sequence with its thirteen multiplies, then the pressure divide.
// Each block mean that completes adds one more divide; a zero divisor skips the
// pressure path and ends the reading early. The 64-step divider and the three-pass
// 32x32 multiplier set how long a reading occupies the unit.
// rst_n is synchronous; it clears the accumulators, held means and control.
// A result held on a stalled out port blocks the next result, not the next input.
module baro_temp_compensate_average_unit
  import btca_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [5:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [19:0]        in_raw_temperature,
  input  logic [19:0]        in_raw_pressure,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_temperature_mean,
  output logic [31:0]        out_pressure_mean,
  output logic signed [31:0] out_fine_temperature,
  output logic               out_temperature_mean_new,
  output logic               out_pressure_mean_new,
  output logic               out_pressure_invalid
);

  cal_t        cal_r;
  cmd_t        cmd;
  stat_t       stat;
  logic        wr_en;
  logic [2:0]  reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[5:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r.temp       <= 48'd0;
      cal_r.pwords_lo  <= 64'd0;
      cal_r.pwords_mid <= 64'd0;
      cal_r.pwords_hi  <= 16'd0;
      cal_r.avg_len    <= 8'd8;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_CAL_TEMP:  cal_r.temp       <= pwdata[47:0];
        REG_CAL_PLOW:  cal_r.pwords_lo  <= pwdata;
        REG_CAL_PMID:  cal_r.pwords_mid <= pwdata;
        REG_CAL_PHIGH: cal_r.pwords_hi  <= pwdata[15:0];
        REG_AVG_LEN:   cal_r.avg_len    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_CAL_TEMP:  prdata = {16'd0, cal_r.temp};
      REG_CAL_PLOW:  prdata = cal_r.pwords_lo;
      REG_CAL_PMID:  prdata = cal_r.pwords_mid;
      REG_CAL_PHIGH: prdata = {48'd0, cal_r.pwords_hi};
      REG_AVG_LEN:   prdata = {56'd0, cal_r.avg_len};
      default:       prdata = 64'd0;
    endcase
  end

  btca_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .stat     (stat),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  btca_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .cal                  (cal_r),
    .raw_temperature      (in_raw_temperature),
    .raw_pressure         (in_raw_pressure),
    .out_ready            (out_ready),
    .stat                 (stat),
    .out_valid            (out_valid),
    .temperature_mean     (out_temperature_mean),
    .pressure_mean        (out_pressure_mean),
    .fine_temperature     (out_fine_temperature),
    .temperature_mean_new (out_temperature_mean_new),
    .pressure_mean_new    (out_pressure_mean_new),
    .pressure_invalid     (out_pressure_invalid)
  );

endmodule

### design/btca_check.sv
// Port-level checks for the compensation unit, bound to the top level.
module btca_check
  import btca_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_pressure_mean,
  input logic        out_pressure_mean_new,
  input logic        out_pressure_invalid
);

  // one reading in flight: input closes right after a transfer
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a reading is in flight");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pressure_invalid |-> out_pressure_mean == 32'd0 && !out_pressure_mean_new)
    else $error("invalid pressure with nonzero mean or new block");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pressure_mean))
    else $error("result dropped or changed while stalled");

endmodule

bind baro_temp_compensate_average_unit btca_check u_btca_check (.*);

### test/tb_baro_temp_compensate_average_unit.sv
// Testbench for the barometric compensation and block-average unit.
`timescale 1ns / 100ps

module tb_baro_temp_compensate_average_unit;
  import btca_pkg::*;

  typedef struct packed {
    logic [19:0] raw_t;
    logic [19:0] raw_p;
  } reading_t;

  typedef struct packed {
    logic signed [15:0] t_mean;
    logic [31:0]        p_mean;
    logic signed [31:0] fine;
    logic               t_new;
    logic               p_new;
    logic               p_inv;
  } reading_result_t;

  localparam int DRAIN_CYCLES = 320;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [5:0]         paddr = '0;
  logic [63:0]        pwdata = '0;
  logic [63:0]        prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [19:0]        in_raw_temperature = '0;
  logic [19:0]        in_raw_pressure = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [15:0] out_temperature_mean;
  logic [31:0]        out_pressure_mean;
  logic signed [31:0] out_fine_temperature;
  logic               out_temperature_mean_new;
  logic               out_pressure_mean_new;
  logic               out_pressure_invalid;

  baro_temp_compensate_average_unit u_dut (.*);

  // calibration mirror and averaging state of the predictor
  logic [47:0] cal_temp = '0;
  logic [63:0] cal_plow = '0;
  logic [63:0] cal_pmid = '0;
  logic [15:0] cal_phigh = '0;
  logic [7:0]  avg_len = 8'd8;
  int          t_sum = 0, t_tally = 0, t_held = 0;
  logic [63:0] p_sum = '0, p_held = '0;
  int          p_tally = 0;

  reading_t        reading_q[$];
  reading_result_t expected_q[$];
  int  send_idle_pct = 0, recv_stall_pct = 0;
  int  mismatches = 0, transfers_in = 0, transfers_out = 0;
  int  t_blocks = 0, p_blocks = 0, invalid_seen = 0;
  logic taken = 1'b0;

  initial forever #4 clk = ~clk;

  initial begin
    #40ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic logic [63:0] shift_down(input logic [63:0] v, input int s);
    return $signed(v) >>> s;
  endfunction

  function automatic logic [63:0] quot_toward_zero(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] mn, md, q;
    mn = n[63] ? -n : n;
    md = d[63] ? -d : d;
    q = mn / md;
    return (n[63] != d[63]) ? -q : q;
  endfunction

  function automatic reading_result_t compensate_reading(input reading_t rd);
    logic [63:0] rt, rp, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [63:0] a, b, d, fine, p, tv;
    longint th;
    int tsat;
    reading_result_t r;
    rt = 64'(rd.raw_t);
    rp = 64'(rd.raw_p);
    t1 = 64'(cal_temp[15:0]);
    t2 = 64'($signed(cal_temp[31:16]));
    t3 = 64'($signed(cal_temp[47:32]));
    p1 = 64'(cal_plow[15:0]);
    p2 = 64'($signed(cal_plow[31:16]));
    p3 = 64'($signed(cal_plow[47:32]));
    p4 = 64'($signed(cal_plow[63:48]));
    p5 = 64'($signed(cal_pmid[15:0]));
    p6 = 64'($signed(cal_pmid[31:16]));
    p7 = 64'($signed(cal_pmid[47:32]));
    p8 = 64'($signed(cal_pmid[63:48]));
    p9 = 64'($signed(cal_phigh));
    r = '0;

    a = shift_down(((rt >> 3) - (t1 << 1)) * t2, 11);
    d = (rt >> 4) - t1;
    b = shift_down(shift_down(d * d, 12) * t3, 14);
    fine = a + b;
    tv = shift_down(fine * 64'd5 + 64'd128, 8);
    th = $signed(tv);
    tsat = (th > 32767) ? 32767 : ((th < -32768) ? -32768 : int'(th));
    t_sum += tsat;
    t_tally++;
    if (t_tally >= int'(avg_len)) begin
      t_held = t_sum / t_tally;
      t_sum = 0;
      t_tally = 0;
      r.t_new = 1'b1;
    end

    a = fine - 64'd128000;
    b = a * a * p6;
    b = b + ((a * p5) << 17);
    b = b + (p4 << 35);
    a = shift_down(a * a * p3, 8) + ((a * p2) << 12);
    a = shift_down(((64'd1 << 47) + a) * p1, 33);
    if (a == 0) begin
      r.p_inv = 1'b1;
    end else begin
      p = 64'd1048576 - rp;
      p = quot_toward_zero(((p << 31) - b) * 64'd3125, a);
      a = shift_down(p9 * shift_down(p, 13) * shift_down(p, 13), 25);
      b = shift_down(p8 * p, 19);
      p = shift_down(p + a + b, 8) + (p7 << 4);
      if (p[63]) p = '0;
      else if (p > 64'hFFFF_FFFF) p = 64'hFFFF_FFFF;
      p_sum += p;
      p_tally++;
      if (p_tally >= int'(avg_len)) begin
        p_held = p_sum / 64'(p_tally);
        p_sum = '0;
        p_tally = 0;
        r.p_new = 1'b1;
      end
      r.p_mean = p_held[31:0];
    end
    r.t_mean = t_held[15:0];
    r.fine = fine[31:0];
    return r;
  endfunction

  // capture each input transfer and predict its result
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      expected_q.push_back(compensate_reading({in_raw_temperature, in_raw_pressure}));
      transfers_in++;
      taken <= 1'b1;
    end else begin
      taken <= 1'b0;
    end
  end

  always @(negedge clk) begin
    reading_t rd;
    if (rst_n && (!in_valid || taken)) begin
      if (reading_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        rd = reading_q.pop_front();
        in_raw_temperature <= rd.raw_t;
        in_raw_pressure <= rd.raw_p;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    reading_result_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got = {out_temperature_mean, out_pressure_mean, out_fine_temperature,
             out_temperature_mean_new, out_pressure_mean_new, out_pressure_invalid};
      transfers_out++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer: %h", got);
      end else begin
        want = expected_q.pop_front();
        t_blocks += want.t_new;
        p_blocks += want.p_new;
        invalid_seen += want.p_inv;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch #%0d: t_mean %0d/%0d p_mean %h/%h fine %0d/%0d flags %b/%b",
                     transfers_out, want.t_mean, got.t_mean, want.p_mean, got.p_mean,
                     want.fine, got.fine, {want.t_new, want.p_new, want.p_inv},
                     {got.t_new, got.p_new, got.p_inv});
        end
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_CAL_TEMP:  cal_temp = value[47:0];
      REG_CAL_PLOW:  cal_plow = value;
      REG_CAL_PMID:  cal_pmid = value;
      REG_CAL_PHIGH: cal_phigh = value[15:0];
      REG_AVG_LEN:   avg_len = value[7:0];
      default: ;
    endcase
  endtask

  // hold until the block has drained, then give it time to go idle
  task automatic drain();
    while (reading_q.size() > 0 || in_valid || expected_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_cal(input logic [47:0] ct, input logic [63:0] pl, input logic [63:0] pm,
                          input logic [15:0] ph, input logic [7:0] len);
    write_reg(REG_CAL_TEMP, 64'(ct));
    write_reg(REG_CAL_PLOW, pl);
    write_reg(REG_CAL_PMID, pm);
    write_reg(REG_CAL_PHIGH, 64'(ph));
    write_reg(REG_AVG_LEN, 64'(len));
  endtask

  function automatic logic [15:0] jitter(input logic [15:0] w);
    return w + 16'($urandom_range(0, 64)) - 16'd32;
  endfunction

  localparam logic [47:0] TYP_TEMP = {16'hFC18, 16'd26435, 16'd27504};
  localparam logic [63:0] TYP_PLOW = {16'd2855, 16'd3024, 16'hD643, 16'd36477};
  localparam logic [63:0] TYP_PMID = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};
  localparam logic [15:0] TYP_PHIGH = 16'd6000;

  initial begin
    logic [47:0] ct;
    logic [63:0] pl, pm;
    logic [15:0] ph;
    logic [7:0]  len;
    int kind, n;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // reset calibration: the pressure divisor is zero on every reading
    reading_q.push_back({20'd0, 20'd0});
    reading_q.push_back({20'hFFFFF, 20'hFFFFF});
    reading_q.push_back({20'd519888, 20'd415148});
    reading_q.push_back({20'hAAAAA, 20'h55555});
    drain();

    // typical calibration, single-reading blocks, extremes of the raw fields
    load_cal(TYP_TEMP, TYP_PLOW, TYP_PMID, TYP_PHIGH, 8'd1);
    reading_q.push_back({20'd0, 20'd0});
    reading_q.push_back({20'hFFFFF, 20'd0});
    reading_q.push_back({20'd0, 20'hFFFFF});
    reading_q.push_back({20'hFFFFF, 20'hFFFFF});
    reading_q.push_back({20'd519888, 20'd415148});
    reading_q.push_back({20'h80000, 20'h80000});
    drain();

    // zero block length, then all-ones calibration
    write_reg(REG_AVG_LEN, 64'd0);
    reading_q.push_back({20'd519888, 20'd415148});
    reading_q.push_back({20'd400000, 20'd300000});
    drain();
    load_cal('1, '1, '1, '1, 8'd255);
    reading_q.push_back({20'd0, 20'hFFFFF});
    reading_q.push_back({20'hFFFFF, 20'd0});
    reading_q.push_back({20'd12345, 20'd678});
    drain();

    // lower the length mid-block: the next reading closes the short block
    load_cal(TYP_TEMP, TYP_PLOW, TYP_PMID, TYP_PHIGH, 8'd5);
    reading_q.push_back({20'd519888, 20'd415148});
    reading_q.push_back({20'd519000, 20'd416000});
    drain();
    write_reg(REG_AVG_LEN, 64'd2);
    reading_q.push_back({20'd520500, 20'd414000});
    reading_q.push_back({20'd521000, 20'd413000});
    drain();

    for (int ph_i = 0; ph_i < 12; ph_i++) begin
      case (ph_i % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      kind = $urandom_range(99);
      if (kind < 60) begin
        ct = {jitter(TYP_TEMP[47:32]), jitter(TYP_TEMP[31:16]), jitter(TYP_TEMP[15:0])};
        pl = {jitter(TYP_PLOW[63:48]), jitter(TYP_PLOW[47:32]), jitter(TYP_PLOW[31:16]),
              jitter(TYP_PLOW[15:0])};
        pm = {jitter(TYP_PMID[63:48]), jitter(TYP_PMID[47:32]), jitter(TYP_PMID[31:16]),
              jitter(TYP_PMID[15:0])};
        ph = jitter(TYP_PHIGH);
      end else begin
        ct = 48'({$urandom, $urandom});
        pl = {$urandom, $urandom};
        pm = {$urandom, $urandom};
        ph = 16'($urandom);
        if (kind >= 88) pl[15:0] = '0;
      end
      kind = $urandom_range(99);
      if (kind < 75) len = 8'($urandom_range(1, 16));
      else if (kind < 85) len = 8'd255;
      else if (kind < 92) len = 8'd0;
      else len = 8'($urandom);
      load_cal(ct, pl, pm, ph, len);
      n = $urandom_range(65, 85);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(99) < 70)
          reading_q.push_back({20'($urandom_range(380000, 620000)),
                               20'($urandom_range(200000, 600000))});
        else
          reading_q.push_back({20'($urandom), 20'($urandom)});
      end
      drain();
    end

    $display("readings in: %0d, results out: %0d", transfers_in, transfers_out);
    $display("temperature blocks: %0d, pressure blocks: %0d, zero-divisor readings: %0d",
             t_blocks, p_blocks, invalid_seen);
    if (mismatches == 0 && expected_q.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
